>>> hw/rtl/vpfa_pkg.sv
// ----------------------------------------------------------------------------
// vpfa_pkg
// Shared constants and types of the variable partition fit allocator.
// ----------------------------------------------------------------------------
package vpfa_pkg;

  localparam int NUM_PARTITIONS = 8;
  localparam int SIZE_WIDTH     = 16;
  localparam int SEL_W          = 3;
  localparam int COUNT_W        = 4;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 4;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY          = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 1'b1;

  typedef struct packed {
    logic                  we;
    logic [SEL_W-1:0]      addr;
    logic [SIZE_WIDTH-1:0] data;
  } ram_wr_t;

endpackage

>>> hw/rtl/vpfa_if.sv
// ----------------------------------------------------------------------------
// vpfa_in_if / vpfa_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface vpfa_in_if;
  import vpfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [SEL_W-1:0]      partition_select;
  logic [SIZE_WIDTH-1:0] amount;

  modport source (output valid, output action, output partition_select,
                  output amount, input ready);
  modport sink (input valid, input action, input partition_select,
                input amount, output ready);
endinterface

interface vpfa_out_if;
  import vpfa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  granted;
  logic [SEL_W-1:0]      chosen_partition;
  logic [SIZE_WIDTH-1:0] space_left;

  modport source (output valid, output granted, output chosen_partition,
                  output space_left, input ready);
  modport sink (input valid, input granted, input chosen_partition,
                input space_left, output ready);
endinterface

>>> hw/rtl/vpfa_ram.sv
// ----------------------------------------------------------------------------
// vpfa_ram
// Free-space memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module vpfa_ram
  import vpfa_pkg::*;
(
  input  logic                  clk,
  input  ram_wr_t               wr,
  input  logic [SEL_W-1:0]      raddr,
  output logic [SIZE_WIDTH-1:0] rdata
);

  logic [SIZE_WIDTH-1:0] mem [NUM_PARTITIONS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/vpfa_ctrl.sv
// ----------------------------------------------------------------------------
// vpfa_ctrl
// Sequencer that loads free space, or scans the free-space memory, picks a
// partition under the selected policy and writes the updated free space back.
// ----------------------------------------------------------------------------
module vpfa_ctrl
  import vpfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vpfa_in_if.sink               in_ch,
  vpfa_out_if.source            out_ch,
  output ram_wr_t               ram_wr,
  output logic [SEL_W-1:0]      ram_raddr,
  input  logic [SIZE_WIDTH-1:0] ram_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  function automatic logic [SEL_W-1:0] wrap_next(input logic [SEL_W-1:0] j,
                                                 input logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] j1;
    j1 = {1'b0, j} + COUNT_W'(1);
    return (j1 < n) ? j1[SEL_W-1:0] : '0;
  endfunction

  state_t                state_r, state_nxt;
  policy_t               policy_r, policy_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [SEL_W-1:0]      next_start_r, next_start_nxt;
  logic                  act_r, act_nxt;
  logic [SEL_W-1:0]      sel_r, sel_nxt;
  logic [SIZE_WIDTH-1:0] amt_r, amt_nxt;
  logic [COUNT_W-1:0]    n_r, n_nxt;
  logic [SEL_W-1:0]      k_r, k_nxt;
  logic [SEL_W-1:0]      j_r, j_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [SEL_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  found_r, found_nxt;
  logic [SEL_W-1:0]      fidx_r, fidx_nxt;
  logic [SIZE_WIDTH-1:0] ffree_r, ffree_nxt;
  logic                  ov_r, ov_nxt;
  logic                  og_r, og_nxt;
  logic [SEL_W-1:0]      oc_r, oc_nxt;
  logic [SIZE_WIDTH-1:0] os_r, os_nxt;

  logic [COUNT_W-1:0]    n_act;
  logic                  accept;
  logic                  out_free;
  logic                  load_ok;
  logic                  fits;
  logic                  better;
  logic [SIZE_WIDTH-1:0] left;

  assign n_act     = (count_r > COUNT_W'(NUM_PARTITIONS)) ? COUNT_W'(NUM_PARTITIONS)
                                                          : count_r;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign out_free  = !ov_r || out_ch.ready;
  assign load_ok   = ({1'b0, sel_r} < COUNT_W'(NUM_PARTITIONS));
  assign fits      = (ram_rdata >= amt_r);
  assign better    = !found_r ||
                     ((policy_r == POL_BEST) && (ram_rdata < ffree_r)) ||
                     ((policy_r == POL_WORST) && (ram_rdata > ffree_r));
  assign left      = ffree_r - amt_r;
  assign ram_raddr = j_r;

  assign out_ch.valid            = ov_r;
  assign out_ch.granted          = og_r;
  assign out_ch.chosen_partition = oc_r;
  assign out_ch.space_left       = os_r;

  always_comb begin
    state_nxt      = state_r;
    policy_nxt     = policy_r;
    count_nxt      = count_r;
    next_start_nxt = next_start_r;
    act_nxt        = act_r;
    sel_nxt        = sel_r;
    amt_nxt        = amt_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    ffree_nxt      = ffree_r;
    ov_nxt         = ov_r && !out_ch.ready;
    og_nxt         = og_r;
    oc_nxt         = oc_r;
    os_nxt         = os_r;
    ram_wr         = '0;

    if (cfg_we) begin
      if (cfg_index == REG_POLICY) begin
        policy_nxt = policy_t'(cfg_wdata[1:0]);
      end else begin
        count_nxt = cfg_wdata;
      end
    end

    if (rd_vld_r && fits && better) begin
      found_nxt = 1'b1;
      fidx_nxt  = rd_idx_r;
      ffree_nxt = ram_rdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = in_ch.action;
          sel_nxt   = in_ch.partition_select;
          amt_nxt   = in_ch.amount;
          n_nxt     = n_act;
          found_nxt = 1'b0;
          fidx_nxt  = '0;
          ffree_nxt = '0;
          k_nxt     = '0;
          j_nxt     = ((policy_r == POL_NEXT) && ({1'b0, next_start_r} < n_act))
                      ? next_start_r : '0;
          if ((in_ch.action == ACT_LOAD) || (n_act == '0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = j_r;
        j_nxt      = wrap_next(j_r, n_r);
        k_nxt      = k_r + SEL_W'(1);
        if (({1'b0, k_r} + COUNT_W'(1)) == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          state_nxt = ST_IDLE;
          if (act_r == ACT_LOAD) begin
            og_nxt = 1'b0;
            oc_nxt = sel_r;
            os_nxt = load_ok ? amt_r : '0;
            if (load_ok) begin
              ram_wr.we   = 1'b1;
              ram_wr.addr = sel_r;
              ram_wr.data = amt_r;
              if (sel_r == '0) begin
                next_start_nxt = '0;
              end
            end
          end else if (found_r) begin
            og_nxt         = 1'b1;
            oc_nxt         = fidx_r;
            os_nxt         = left;
            ram_wr.we      = 1'b1;
            ram_wr.addr    = fidx_r;
            ram_wr.data    = left;
            next_start_nxt = wrap_next(fidx_r, n_r);
          end else begin
            og_nxt = 1'b0;
            oc_nxt = '0;
            os_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      policy_r     <= POL_FIRST;
      count_r      <= COUNT_W'(NUM_PARTITIONS);
      next_start_r <= '0;
      rd_vld_r     <= 1'b0;
      ov_r         <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      policy_r     <= policy_nxt;
      count_r      <= count_nxt;
      next_start_r <= next_start_nxt;
      rd_vld_r     <= rd_vld_nxt;
      ov_r         <= ov_nxt;
      found_r      <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    sel_r    <= sel_nxt;
    amt_r    <= amt_nxt;
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    rd_idx_r <= rd_idx_nxt;
    fidx_r   <= fidx_nxt;
    ffree_r  <= ffree_nxt;
    og_r     <= og_nxt;
    oc_r     <= oc_nxt;
    os_r     <= os_nxt;
  end

endmodule

>>> hw/rtl/variable_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_fit_allocator
// Partition allocator with first, next, best and worst fit placement.
// ----------------------------------------------------------------------------
// A load item goes to the finish state, which registers its result once the
// output is free. An allocate item first scans the n partitions in use,
// walking the single memory read port one entry a cycle, then drains and
// finishes alike. The next item can be accepted once its result is valid.
// Synchronous active-low reset restores policy, count and next-fit start;
// the free-space memory is not cleared and holds nothing until loaded.
module variable_partition_fit_allocator
  import vpfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  vpfa_in_if.sink               in_ch,
  vpfa_out_if.source            out_ch
);

  ram_wr_t               ram_wr;
  logic [SEL_W-1:0]      ram_raddr;
  logic [SIZE_WIDTH-1:0] ram_rdata;

  vpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  vpfa_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hw/rtl/vpfa_checker.sv
// ----------------------------------------------------------------------------
// vpfa_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vpfa_checker
  import vpfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_granted,
  input logic [SEL_W-1:0]      out_chosen_partition,
  input logic [SIZE_WIDTH-1:0] out_space_left
);

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_granted) &&
      $stable(out_chosen_partition) && $stable(out_space_left))
    else $error("stalled result item changed");

  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_result_after_work : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item appeared without an item in flight");

endmodule

bind variable_partition_fit_allocator vpfa_checker u_vpfa_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_granted          (out_ch.granted),
  .out_chosen_partition (out_ch.chosen_partition),
  .out_space_left       (out_ch.space_left)
);
